// ===== design/fr_pkg.sv =====
// Shared types and constants for the fraction reducer.
`timescale 1ns / 1ps
package fr_pkg;

  // Default operand width and fixed port widths
  localparam int FR_WIDTH = 32;
  localparam int FIELD_W  = 32;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NUM_ZERO = 2'd1,
    ST_DEN_ZERO = 2'd2
  } fr_status_t;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_GCD,
    S_DIVN,
    S_MID,
    S_DIVD,
    S_DONE
  } fr_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;        // capture input word
    logic gcd_step;    // one binary gcd step
    logic div_init_x;  // start dividing the numerator
    logic div_step;    // one restoring division step
    logic div_mid;     // save numerator quotient, start the denominator
    logic out_load;    // fill output register
  } fr_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic special;     // zero numerator or zero denominator
    logic gcd_done;    // both operands odd and equal
  } fr_stat_t;

endpackage

// ===== design/fr_ctrl.sv =====
// Controller state machine for the fraction reducer.
`timescale 1ns / 1ps
module fr_ctrl
  import fr_pkg::*;
#(
  parameter int WIDTH = FR_WIDTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  fr_stat_t stat,
  output fr_cmd_t  cmd
);

  localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;
  localparam logic [CW-1:0] LAST = CW'(WIDTH - 1);

  fr_state_t     state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          out_valid_r, out_valid_nxt;

  // State, step counter and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign in_ready  = (state_r == S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r & ~out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_GCD;
        end
      end
      S_GCD: begin
        if (stat.special) begin
          state_nxt = S_DONE;
        end else if (stat.gcd_done) begin
          cmd.div_init_x = 1'b1;
          cnt_nxt        = '0;
          state_nxt      = S_DIVN;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      S_DIVN: begin
        cmd.div_step = 1'b1;
        if (cnt_r == LAST) begin
          state_nxt = S_MID;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_MID: begin
        cmd.div_mid = 1'b1;
        cnt_nxt     = '0;
        state_nxt   = S_DIVD;
      end
      S_DIVD: begin
        cmd.div_step = 1'b1;
        if (cnt_r == LAST) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DONE: begin
        // wait until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== design/fr_dpath.sv =====
// Datapath for the fraction reducer: binary gcd, shared divider, output register.
`timescale 1ns / 1ps
module fr_dpath
  import fr_pkg::*;
#(
  parameter int WIDTH = FR_WIDTH
) (
  input  logic               clk,
  input  logic [FIELD_W-1:0] in_numerator,
  input  logic [FIELD_W-1:0] in_denominator,
  input  fr_cmd_t            cmd,
  output fr_stat_t           stat,
  output logic [1:0]         out_status,
  output logic [FIELD_W-1:0] out_reduced_numerator,
  output logic [FIELD_W-1:0] out_reduced_denominator,
  output logic               out_is_whole
);

  localparam logic [WIDTH-1:0] ONE = WIDTH'(1);

  // Input words cut or zero-extended to WIDTH bits
  logic [WIDTH+FIELD_W-1:0] num_ext, den_ext;
  logic [WIDTH-1:0]         num_w, den_w;

  assign num_ext = {{WIDTH{1'b0}}, in_numerator};
  assign den_ext = {{WIDTH{1'b0}}, in_denominator};
  assign num_w   = num_ext[WIDTH-1:0];
  assign den_w   = den_ext[WIDTH-1:0];

  logic [WIDTH-1:0] a_r, b_r;   // gcd operands
  logic [WIDTH-1:0] x_r, y_r;   // numerator and denominator with common twos removed
  logic [WIDTH-1:0] q_r, r_r;   // divider quotient/dividend and remainder
  logic [WIDTH-1:0] rn_r;       // reduced numerator
  fr_status_t       stat_r;

  fr_status_t         out_status_r;
  logic [WIDTH-1:0]   out_num_r, out_den_r;
  logic               out_whole_r;

  // gcd step arithmetic
  logic             a_gt_b;
  logic [WIDTH-1:0] a_sub_b, b_sub_a;

  assign a_gt_b  = (a_r > b_r);
  assign a_sub_b = a_r - b_r;
  assign b_sub_a = b_r - a_r;

  assign stat.special  = (stat_r != ST_OK);
  assign stat.gcd_done = a_r[0] & b_r[0] & (a_r == b_r);

  // restoring division step, divisor is the odd gcd in a_r
  logic [WIDTH:0] rem_sh, diff;

  assign rem_sh = {r_r, q_r[WIDTH-1]};
  assign diff   = rem_sh - {1'b0, a_r};

  // Operand, divider and status registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_r <= num_w;
      b_r <= den_w;
      x_r <= num_w;
      y_r <= den_w;
      if (den_w == '0) begin
        stat_r <= ST_DEN_ZERO;
      end else if (num_w == '0) begin
        stat_r <= ST_NUM_ZERO;
      end else begin
        stat_r <= ST_OK;
      end
    end else if (cmd.gcd_step) begin
      if (!a_r[0] && !b_r[0]) begin
        // shared factor of two: drop it from everything
        a_r <= a_r >> 1;
        b_r <= b_r >> 1;
        x_r <= x_r >> 1;
        y_r <= y_r >> 1;
      end else if (!a_r[0]) begin
        a_r <= a_r >> 1;
      end else if (!b_r[0]) begin
        b_r <= b_r >> 1;
      end else if (a_gt_b) begin
        a_r <= a_sub_b >> 1;
      end else if (a_r != b_r) begin
        b_r <= b_sub_a >> 1;
      end
    end

    if (cmd.div_init_x) begin
      q_r <= x_r;
      r_r <= '0;
    end else if (cmd.div_mid) begin
      rn_r <= q_r;
      q_r  <= y_r;
      r_r  <= '0;
    end else if (cmd.div_step) begin
      if (!diff[WIDTH]) begin
        r_r <= diff[WIDTH-1:0];
        q_r <= {q_r[WIDTH-2:0], 1'b1};
      end else begin
        r_r <= rem_sh[WIDTH-1:0];
        q_r <= {q_r[WIDTH-2:0], 1'b0};
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= stat_r;
      if (stat_r == ST_OK) begin
        out_num_r   <= rn_r;
        out_den_r   <= q_r;
        out_whole_r <= (q_r == ONE);
      end else begin
        out_num_r   <= '0;
        out_den_r   <= '0;
        out_whole_r <= 1'b0;
      end
    end
  end

  // Fit results to the port width
  logic [WIDTH+FIELD_W-1:0] on_ext, od_ext;

  assign on_ext = {{FIELD_W{1'b0}}, out_num_r};
  assign od_ext = {{FIELD_W{1'b0}}, out_den_r};

  assign out_status              = out_status_r;
  assign out_reduced_numerator   = on_ext[FIELD_W-1:0];
  assign out_reduced_denominator = od_ext[FIELD_W-1:0];
  assign out_is_whole            = out_whole_r;

endmodule

// ===== design/fraction_reducer.sv =====
// Top level of the fraction reducer: controller plus datapath.
//
//   channel  direction  handshake             words
//   in_      input      in_valid/in_ready     in_numerator, in_denominator
//   out_     output     out_valid/out_ready   out_status, out_reduced_numerator,
//                                             out_reduced_denominator, out_is_whole
//
// One word at a time. Per word: a load, binary gcd steps (one shift or subtract-and-shift
// per cycle), the numerator then the denominator through the shared one-bit-per-cycle divider,
// and a fill of the output register. A zero operand skips the gcd steps and the divider.
// Synchronous active-low reset clears the controller and output valid only.
// The output register holds a finished word under out_ready low; the next input word is
// taken meanwhile and waits at completion until the register frees.
`timescale 1ns / 1ps
module fraction_reducer
  import fr_pkg::*;
#(
  parameter int WIDTH = FR_WIDTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [FIELD_W-1:0] in_numerator,
  input  logic [FIELD_W-1:0] in_denominator,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic [FIELD_W-1:0] out_reduced_numerator,
  output logic [FIELD_W-1:0] out_reduced_denominator,
  output logic               out_is_whole
);

  fr_cmd_t  cmd;
  fr_stat_t stat;

  fr_ctrl #(
    .WIDTH (WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  fr_dpath #(
    .WIDTH (WIDTH)
  ) u_dpath (
    .clk                     (clk),
    .in_numerator            (in_numerator),
    .in_denominator          (in_denominator),
    .cmd                     (cmd),
    .stat                    (stat),
    .out_status              (out_status),
    .out_reduced_numerator   (out_reduced_numerator),
    .out_reduced_denominator (out_reduced_denominator),
    .out_is_whole            (out_is_whole)
  );

endmodule

// ===== bench/tb_fraction_reducer.sv =====
// Self-checking testbench for fraction_reducer: random words checked against a gcd predictor.
`timescale 1ns / 1ps
module tb_fraction_reducer
  import fr_pkg::*;
();

  localparam int          OPW          = FR_WIDTH;
  localparam logic [63:0] OP_MASK      = ((64'd1 << (OPW - 1)) << 1) - 64'd1;
  localparam int          CYCLE_LIMIT  = 1_000_000;
  localparam int          DRAIN_CYCLES = 4 * OPW + 64;

  // One reduced fraction as the block reports it
  typedef struct {
    fr_status_t         status;
    logic [FIELD_W-1:0] rnum;
    logic [FIELD_W-1:0] rden;
    logic               whole;
  } reduced_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [FIELD_W-1:0] in_numerator = '0;
  logic [FIELD_W-1:0] in_denominator = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         out_status;
  logic [FIELD_W-1:0] out_reduced_numerator;
  logic [FIELD_W-1:0] out_reduced_denominator;
  logic               out_is_whole;

  reduced_t pending_results[$];
  int       mismatches  = 0;
  int       cycle_count = 0;
  bit       no_idle     = 1'b0;   // both sides run without gaps while set
  int       ready_hold  = 0;

  fraction_reducer #(.WIDTH(OPW)) DUT (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_ready                (in_ready),
    .in_numerator            (in_numerator),
    .in_denominator          (in_denominator),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .out_status              (out_status),
    .out_reduced_numerator   (out_reduced_numerator),
    .out_reduced_denominator (out_reduced_denominator),
    .out_is_whole            (out_is_whole)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Lowest terms by Euclid; zero denominator wins over zero numerator
  function automatic reduced_t reduce_fraction(input logic [FIELD_W-1:0] n,
                                               input logic [FIELD_W-1:0] d);
    logic [63:0] num, den, a, b, r;
    reduced_t    res;
    num = {32'd0, n} & OP_MASK;
    den = {32'd0, d} & OP_MASK;
    res.status = ST_OK;
    res.rnum   = '0;
    res.rden   = '0;
    res.whole  = 1'b0;
    if (den == 0) begin
      res.status = ST_DEN_ZERO;
    end else if (num == 0) begin
      res.status = ST_NUM_ZERO;
    end else begin
      a = den;
      b = num;
      while (b != 0) begin
        r = a % b;
        a = b;
        b = r;
      end
      res.rnum  = FIELD_W'((num / a) & OP_MASK);
      res.rden  = FIELD_W'((den / a) & OP_MASK);
      res.whole = ((den / a) == 64'd1);
    end
    return res;
  endfunction

  // Random value of at most the given number of bits
  function automatic logic [FIELD_W-1:0] rand_bits(input int bits);
    logic [63:0] m;
    m = (64'd1 << bits) - 64'd1;
    return $urandom & m[FIELD_W-1:0];
  endfunction

  // Present one word, hold it until taken, then record its expected result.
  // Valid stays high on return so a following word goes out without a gap.
  task automatic send_fraction(input logic [FIELD_W-1:0] n, input logic [FIELD_W-1:0] d);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_numerator   <= n;
    in_denominator <= d;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(reduce_fraction(n, d));
  endtask

  task automatic wait_results_done();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Zero operands, alone and together
  task automatic test_special_cases();
    send_fraction(32'd0, 32'd0);
    send_fraction(32'd5, 32'd0);
    send_fraction(32'd0, 32'd7);
    send_fraction(32'hFFFF_FFFF, 32'd0);
    send_fraction(32'd0, 32'hFFFF_FFFF);
    send_fraction(32'd1, 32'd0);
    send_fraction(32'd0, 32'd1);
    wait_results_done();
  endtask

  // Field extremes and long Euclid chains
  task automatic test_extremes();
    send_fraction(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_fraction(32'hFFFF_FFFF, 32'd1);
    send_fraction(32'd1, 32'hFFFF_FFFF);
    send_fraction(32'hFFFF_FFFE, 32'hFFFF_FFFF);
    send_fraction(32'h8000_0000, 32'h4000_0000);
    send_fraction(32'd3, 32'h8000_0000);
    send_fraction(32'hAAAA_AAAA, 32'h5555_5555);
    send_fraction(32'd2971215073, 32'd1836311903);   // consecutive Fibonacci, gcd 1
    send_fraction(32'd6, 32'd4);
    wait_results_done();
  endtask

  // Whole flag follows the reduced denominator, not the numerator
  task automatic test_whole_numbers(input int count);
    logic [FIELD_W-1:0] d;
    int                 k;
    send_fraction(32'd1, 32'd1);
    send_fraction(32'd12, 32'd4);
    send_fraction(32'd4, 32'd12);
    send_fraction(32'd1, 32'd5);
    send_fraction(32'd7, 32'd7);
    send_fraction(32'h8000_0000, 32'd1);
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(1, 31);
      d = rand_bits(k);
      if (d == 0) d = 32'd1;
      send_fraction(d * rand_bits(32 - k), d);
    end
    wait_results_done();
  endtask

  // Pairs built around a shared factor so the gcd is not trivial
  task automatic test_common_factors(input int count);
    logic [FIELD_W-1:0] g;
    int                 gbits;
    for (int i = 0; i < count; i++) begin
      gbits = $urandom_range(1, 20);
      g = rand_bits(gbits);
      if (g == 0) g = 32'd1;
      send_fraction(g * rand_bits(32 - gbits), g * rand_bits(32 - gbits));
    end
    wait_results_done();
  endtask

  // Same shape of traffic with no gaps on either side
  task automatic test_back_to_back(input int count);
    no_idle = 1'b1;
    test_common_factors(count);
    no_idle = 1'b0;
  endtask

  // Unrelated pairs over all sizes, with some zero operands mixed in
  task automatic test_random_pairs(input int count);
    int kind;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(0, 19);
      case (kind)
        0: begin
          send_fraction($urandom, 32'd0);
        end
        1: begin
          send_fraction(32'd0, $urandom);
        end
        2, 3, 4, 5, 6, 7, 8, 9: begin
          send_fraction($urandom, $urandom);
        end
        default: begin
          send_fraction(rand_bits($urandom_range(1, 32)), rand_bits($urandom_range(1, 32)));
        end
      endcase
    end
    wait_results_done();
  endtask

  // Result side: random stall after each word, compare against the oldest expectation
  always @(posedge clk) begin : result_check
    reduced_t want;
    int       stall;
    if (!rst_n) begin
      out_ready  <= 1'b0;
      ready_hold <= 0;
    end else if (out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected out word: status %0d num %0h den %0h whole %0b",
               out_status, out_reduced_numerator, out_reduced_denominator, out_is_whole);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status) begin
          $error("out_status: expected %0d, got %0d", want.status, out_status);
          mismatches++;
        end
        if (out_reduced_numerator !== want.rnum) begin
          $error("out_reduced_numerator: expected %0h, got %0h",
                 want.rnum, out_reduced_numerator);
          mismatches++;
        end
        if (out_reduced_denominator !== want.rden) begin
          $error("out_reduced_denominator: expected %0h, got %0h",
                 want.rden, out_reduced_denominator);
          mismatches++;
        end
        if (out_is_whole !== want.whole) begin
          $error("out_is_whole: expected %0b, got %0b", want.whole, out_is_whole);
          mismatches++;
        end
      end
      stall = no_idle ? 0 : $urandom_range(0, 3);
      ready_hold <= stall;
      out_ready  <= (stall == 0);
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      out_ready  <= (ready_hold == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Run watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_fraction_reducer: FAIL");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_special_cases();
    test_extremes();
    test_whole_numbers(200);
    test_common_factors(450);
    test_back_to_back(100);
    test_random_pairs(530);
    wait_results_done();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_fraction_reducer: PASS");
    end else begin
      $display("tb_fraction_reducer: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/fr_pkg.sv
design/fr_ctrl.sv
design/fr_dpath.sv
design/fraction_reducer.sv
bench/tb_fraction_reducer.sv
